// ===== rtl/core/tsag_pkg.sv =====
// shared types and constants for the tile source address generator
package tsag_pkg;

  localparam int unsigned IDX_W   = 31;  // table values and element indexes
  localparam int unsigned ADDR_W  = 32;  // emitted addresses
  localparam int unsigned AXIS_W  = 3;
  localparam int unsigned RANK_W  = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  // restoring divider walks one dividend bit per cycle
  localparam int unsigned DIV_STEPS = IDX_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_RANK_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE   = 1'b1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_MAP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AXIS,
    ST_DIV_COORD,
    ST_DIM_CHK,
    ST_DIV_DIM,
    ST_MUL,
    ST_ACC,
    ST_EMIT_LO,
    ST_EMIT_HI
  } state_e;

endpackage

// ===== rtl/core/tile_source_address_generator.sv =====
// a map item walks each of its axes in turn (two divides on one
// shared restoring divider, a setup, a dimension check, a multiply and an add)
// load items give no result; no new item is taken while a map item runs
// the divider's one-bit-per-cycle loop sets the rate; wide mode also emits the high word
// reset clears control state and sets rank_in_use to 1 and wide_mode to 0
// the axis tables are undefined after reset until loaded
module tile_source_address_generator import tsag_pkg::*; #(
  parameter int unsigned MAX_RANK = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic [AXIS_W-1:0]     axis_number_i,
  input  logic [IDX_W-1:0]      out_stride_value_i,
  input  logic [IDX_W-1:0]      in_dim_value_i,
  input  logic [IDX_W-1:0]      in_stride_value_i,
  input  logic [IDX_W-1:0]      out_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ADDR_W-1:0]     src_addr_o,
  output logic [ADDR_W-1:0]     dst_addr_o,
  output logic                  error_flag_o,
  output logic                  last_of_run_o
);

  localparam int unsigned AW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int unsigned CW = $clog2(MAX_RANK + 1);

  state_e state_q, state_d;

  logic [RANK_W-1:0]   rank_cfg_q;
  logic                wide_q;
  logic [IDX_W-1:0]    ost_q [MAX_RANK];
  logic [IDX_W-1:0]    idm_q [MAX_RANK];
  logic [IDX_W-1:0]    ist_q [MAX_RANK];

  logic [CW-1:0]        axis_q;
  logic [CW-1:0]        rank_q;
  logic [IDX_W-1:0]     oidx_q;
  logic [IDX_W-1:0]     idx_q;
  logic [ADDR_W-1:0]    src_q;
  logic                 err_q;
  logic [IDX_W-1:0]     quo_q;
  logic [IDX_W-1:0]     rem_q;
  logic [IDX_W-1:0]     dvsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [ADDR_W-1:0]    prod_q;

  logic                 in_acc;
  logic                 out_acc;
  logic                 axis_done;
  logic                 div_last;
  logic [ADDR_W-1:0]    div_shift;
  logic                 div_ge;
  logic [ADDR_W-1:0]    div_diff;
  logic [IDX_W-1:0]     ost_rd;
  logic [IDX_W-1:0]     idm_rd;
  logic [IDX_W-1:0]     ist_rd;
  logic [2*IDX_W-1:0]   mul_full;
  logic [CW-1:0]        rank_clamp;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign ost_rd = ost_q[axis_q[AW-1:0]];
  assign idm_rd = idm_q[axis_q[AW-1:0]];
  assign ist_rd = ist_q[axis_q[AW-1:0]];

  assign axis_done = (axis_q == rank_q);
  assign div_last  = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  // one restoring step: shift in the next dividend bit, subtract when it fits
  assign div_shift = {rem_q, quo_q[IDX_W-1]};
  assign div_ge    = (div_shift >= {1'b0, dvsr_q});
  assign div_diff  = div_shift - {1'b0, dvsr_q};

  assign mul_full = rem_q * ist_rd;

  assign rank_clamp = (32'(rank_cfg_q) > MAX_RANK) ? CW'(MAX_RANK) : CW'(rank_cfg_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && action_i == ACT_MAP) begin
          state_d = ST_AXIS;
        end
      end
      ST_AXIS: begin
        if (axis_done) begin
          state_d = ST_EMIT_LO;
        end else if (ost_rd != '0) begin
          state_d = ST_DIV_COORD;
        end
      end
      ST_DIV_COORD: begin
        if (div_last) begin
          state_d = ST_DIM_CHK;
        end
      end
      ST_DIM_CHK: begin
        state_d = (idm_rd == '0) ? ST_AXIS : ST_DIV_DIM;
      end
      ST_DIV_DIM: begin
        if (div_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: state_d = ST_AXIS;
      ST_EMIT_LO: begin
        if (out_acc) begin
          state_d = wide_q ? ST_EMIT_HI : ST_IDLE;
        end
      end
      ST_EMIT_HI: begin
        if (out_acc) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake and result outputs
  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    out_valid_o   = (state_q == ST_EMIT_LO) || (state_q == ST_EMIT_HI);
    last_of_run_o = (state_q == ST_EMIT_HI) || !wide_q;
    error_flag_o  = err_q;
    if (wide_q) begin
      src_addr_o = {src_q[ADDR_W-2:0], (state_q == ST_EMIT_HI)};
      dst_addr_o = {oidx_q, (state_q == ST_EMIT_HI)};
    end else begin
      src_addr_o = src_q;
      dst_addr_o = {1'b0, oidx_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rank_cfg_q <= RANK_W'(1);
      wide_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RANK_IN_USE: rank_cfg_q <= cfg_wdata_i[RANK_W-1:0];
          CFG_WIDE_MODE:   wide_q     <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // axis tables
  always_ff @(posedge clk_i) begin
    if (in_acc && action_i == ACT_LOAD && 32'(axis_number_i) < MAX_RANK) begin
      ost_q[AW'(axis_number_i)] <= out_stride_value_i;
      idm_q[AW'(axis_number_i)] <= in_dim_value_i;
      ist_q[AW'(axis_number_i)] <= in_stride_value_i;
    end
  end

  // datapath of the walk
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && action_i == ACT_MAP) begin
          oidx_q <= out_index_i;
          idx_q  <= out_index_i;
          src_q  <= '0;
          err_q  <= 1'b0;
          axis_q <= '0;
          rank_q <= rank_clamp;
        end
      end
      ST_AXIS: begin
        if (!axis_done) begin
          if (ost_rd == '0) begin
            // zero stride: index kept, axis adds nothing
            err_q  <= 1'b1;
            axis_q <= axis_q + CW'(1);
          end else begin
            quo_q  <= idx_q;
            rem_q  <= '0;
            dvsr_q <= ost_rd;
            cnt_q  <= '0;
          end
        end
      end
      ST_DIV_COORD, ST_DIV_DIM: begin
        quo_q <= {quo_q[IDX_W-2:0], div_ge};
        rem_q <= div_ge ? div_diff[IDX_W-1:0] : div_shift[IDX_W-1:0];
        cnt_q <= cnt_q + DIV_CNT_W'(1);
      end
      ST_DIM_CHK: begin
        // quotient stays in quo_q as the next dividend
        idx_q <= rem_q;
        if (idm_rd == '0) begin
          err_q  <= 1'b1;
          axis_q <= axis_q + CW'(1);
        end else begin
          rem_q  <= '0;
          dvsr_q <= idm_rd;
          cnt_q  <= '0;
        end
      end
      ST_MUL: prod_q <= mul_full[ADDR_W-1:0];
      ST_ACC: begin
        src_q  <= src_q + prod_q;
        axis_q <= axis_q + CW'(1);
      end
      default: ;
    endcase
  end

endmodule
